### src/gpna_pkg.sv
// shared constants, types and tables of the gaussian pixel noise adder
package gpna_pkg;

  localparam int UNIFORM_BITS_DEF = 16;
  localparam int CORDIC_STEPS = 18;
  localparam int STEP_W = 5;
  localparam logic [24:0] TWO_LN2_Q24 = 25'd23258255;
  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

  localparam logic [1:0] REG_MEAN = 2'd0;
  localparam logic [1:0] REG_DEV  = 2'd1;
  localparam logic [1:0] REG_GAIN = 2'd2;

  localparam logic signed [15:0] MEAN_RST = 16'sd512;
  localparam logic [15:0] DEV_RST = 16'd205;
  localparam logic [7:0] GAIN_RST = 8'd32;

  // datapath commands
  typedef struct packed {
    logic load;      // capture the request and start the radius
    logic log_step;  // one squaring step of log2
    logic r2_mul;    // t * 2ln2
    logic sqrt_step; // one bit of the square root
    logic x_init;    // r * 1/K
    logic rot_step;  // one cordic rotation
    logic finish;    // quadrant fold and q12 rounding
    logic use_held;  // take held sample for this request
    logic mul1;      // z*sigma + mean
    logic mul2;      // times gain
    logic out_load;  // round and saturate into the output register
  } gpna_cmd_t;

  function automatic logic signed [33:0] atan_turn(input logic [STEP_W-1:0] i);
    case (i)
      5'd0: atan_turn = 34'sd536870912;
      5'd1: atan_turn = 34'sd316933406;
      5'd2: atan_turn = 34'sd167458907;
      5'd3: atan_turn = 34'sd85004756;
      5'd4: atan_turn = 34'sd42667331;
      5'd5: atan_turn = 34'sd21354465;
      5'd6: atan_turn = 34'sd10679838;
      5'd7: atan_turn = 34'sd5340245;
      5'd8: atan_turn = 34'sd2670163;
      5'd9: atan_turn = 34'sd1335087;
      5'd10: atan_turn = 34'sd667544;
      5'd11: atan_turn = 34'sd333772;
      5'd12: atan_turn = 34'sd166886;
      5'd13: atan_turn = 34'sd83443;
      5'd14: atan_turn = 34'sd41722;
      5'd15: atan_turn = 34'sd20861;
      5'd16: atan_turn = 34'sd10430;
      5'd17: atan_turn = 34'sd5215;
      default: atan_turn = 34'sd0;
    endcase
  endfunction

endpackage

### src/gpna_datapath.sv
// datapath: log2, square root, cordic, noise scaling and output register
module gpna_datapath #(
  parameter int UNIFORM_BITS = gpna_pkg::UNIFORM_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gpna_pkg::gpna_cmd_t     cmd,
  input  logic [4:0]              step,
  input  logic [7:0]              channel_value,
  input  logic [UNIFORM_BITS-1:0] uniform_a,
  input  logic [UNIFORM_BITS-1:0] uniform_b,
  input  logic signed [15:0]      noise_mean,
  input  logic [15:0]             noise_deviation,
  input  logic [7:0]              noise_gain,
  output logic [7:0]              noisy_value
);

  localparam int PW = $clog2(UNIFORM_BITS + 2);
  localparam int XW = UNIFORM_BITS + 1;

  logic [7:0] chan_r;
  logic [UNIFORM_BITS-1:0] ub_r;
  logic [31:0] m_r;
  logic [15:0] frac_r;
  logic [PW-1:0] p_r;
  logic [47:0] r2_r;
  logic [47:0] sq_rem_r;
  logic [23:0] sq_res_r;
  logic signed [35:0] x_r, y_r;
  logic signed [33:0] ang_r;
  logic signed [15:0] z_r, held_r;
  logic signed [43:0] acc_r;
  logic [7:0] noisy_r;

  // leading-one position of x = code + 1
  logic [XW-1:0] xa;
  logic [PW-1:0] pa;
  logic [31:0] ma;
  always_comb begin
    xa = {1'b0, uniform_a} + XW'(1);
    pa = '0;
    for (int k = 0; k < XW; k++) begin
      if (xa[k]) pa = PW'(k);
    end
    ma = 32'((64'(xa) << 30) >> pa);
  end

  logic [24:0] TWO_LN2_Q24_w;
  assign TWO_LN2_Q24_w = gpna_pkg::TWO_LN2_Q24;

  logic [63:0] msq;
  logic [31:0] mnew;
  logic [PW+15:0] lg;
  logic [PW+15:0] tq;
  logic [PW+40:0] tmul;
  always_comb begin
    msq = 64'(m_r) * 64'(m_r);
    mnew = 32'(msq >> 30);
    lg = {p_r, frac_r};
    tq = ((PW+16)'(UNIFORM_BITS) << 16) > lg ? ((PW+16)'(UNIFORM_BITS) << 16) - lg : '0;
    tmul = (PW+41)'(tq) * (PW+41)'(TWO_LN2_Q24_w);
  end

  // restoring square root, one result bit per cycle from the top pair
  logic [47:0] sq_rem_sh;
  logic [49:0] trial;
  logic [1:0] pair_bits;
  always_comb begin
    pair_bits = 2'(r2_r >> (2 * (23 - int'(step))));
    trial = {sq_rem_r, pair_bits} - {24'd0, sq_res_r, 2'b01};
    sq_rem_sh = 48'({sq_rem_r, pair_bits});
  end

  logic signed [35:0] dx, dy;
  logic signed [33:0] at;
  logic signed [35:0] c, s;
  always_comb begin
    dx = y_r >>> step;
    dy = x_r >>> step;
    at = gpna_pkg::atan_turn(step);
    case (ub_r[UNIFORM_BITS-1 -: 2])
      2'd0: begin c = x_r; s = y_r; end
      2'd1: begin c = -y_r; s = x_r; end
      2'd2: begin c = -x_r; s = -y_r; end
      default: begin c = y_r; s = -x_r; end
    endcase
  end

  function automatic logic signed [15:0] q12sat(input logic signed [35:0] v);
    logic signed [35:0] q;
    q = (v + 36'sd2048) >>> 12;
    if (q > 36'sd32767) q12sat = 16'sh7fff;
    else if (q < -36'sd32768) q12sat = 16'sh8000;
    else q12sat = q[15:0];
  endfunction

  logic signed [43:0] tot;
  logic signed [43:0] rq;
  always_comb begin
    tot = acc_r + 44'(signed'({1'b0, chan_r})) * 44'sd1048576 + 44'sd524288;
    rq = tot >>> 20;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      if (cmd.load) begin
        chan_r <= channel_value;
        ub_r <= uniform_b;
        m_r <= ma;
        p_r <= pa;
        frac_r <= '0;
        sq_rem_r <= '0;
        sq_res_r <= '0;
      end
      if (cmd.use_held) begin
        chan_r <= channel_value;
        z_r <= held_r;
      end
      if (cmd.log_step) begin
        if (mnew[31]) begin
          m_r <= mnew >> 1;
          frac_r <= {frac_r[14:0], 1'b1};
        end else begin
          m_r <= mnew;
          frac_r <= {frac_r[14:0], 1'b0};
        end
      end
      if (cmd.r2_mul) r2_r <= 48'(tmul >> 16);
      if (cmd.sqrt_step) begin
        if (!trial[49]) begin
          sq_rem_r <= trial[47:0];
          sq_res_r <= {sq_res_r[22:0], 1'b1};
        end else begin
          sq_rem_r <= sq_rem_sh;
          sq_res_r <= {sq_res_r[22:0], 1'b0};
        end
      end
      if (cmd.x_init) begin
        x_r <= 36'(signed'({1'b0, 40'(sq_res_r) * 40'(gpna_pkg::INV_GAIN_Q16)}) >>> 4);
        y_r <= '0;
        ang_r <= 34'(signed'({4'd0, 30'(32'(ub_r) << (32 - UNIFORM_BITS))}));
      end
      if (cmd.rot_step) begin
        if (!ang_r[33]) begin
          x_r <= x_r - dx; y_r <= y_r + dy; ang_r <= ang_r - at;
        end else begin
          x_r <= x_r + dx; y_r <= y_r - dy; ang_r <= ang_r + at;
        end
      end
      if (cmd.finish) begin
        z_r <= q12sat(c);
        held_r <= q12sat(s);
      end
      if (cmd.mul1) acc_r <= 44'(z_r) * 44'(signed'({1'b0, noise_deviation}))
                            + (44'(noise_mean) <<< 12);
      if (cmd.mul2) acc_r <= acc_r * 44'(signed'({1'b0, noise_gain}));
      if (cmd.out_load) begin
        if (rq < 0) noisy_r <= 8'd0;
        else if (rq > 44'sd255) noisy_r <= 8'd255;
        else noisy_r <= rq[7:0];
      end
    end
  end

  assign noisy_value = noisy_r;

endmodule

### src/gpna_ctrl.sv
// controller: sequences the datapath for one request at a time
module gpna_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                out_fire,
  output logic                busy,
  output logic                out_valid,
  output logic [4:0]          step,
  output gpna_pkg::gpna_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOG  = 4'd1;
  localparam logic [3:0] S_R2   = 4'd2;
  localparam logic [3:0] S_SQRT = 4'd3;
  localparam logic [3:0] S_XI   = 4'd4;
  localparam logic [3:0] S_ROT  = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;
  localparam logic [3:0] S_MUL1 = 4'd7;
  localparam logic [3:0] S_MUL2 = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic phase_r, phase_nxt;
  logic ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    phase_nxt = phase_r;
    ov_nxt = ov_r && !out_fire;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          phase_nxt = !phase_r;
          if (!phase_r) begin
            cmd.load = 1'b1; state_nxt = S_LOG; step_nxt = '0;
          end else begin
            cmd.use_held = 1'b1; state_nxt = S_MUL1;
          end
        end
      end
      S_LOG: begin
        cmd.log_step = 1'b1; step_nxt = step_r + 5'd1;
        if (step_r == 5'd15) state_nxt = S_R2;
      end
      S_R2: begin
        cmd.r2_mul = 1'b1; state_nxt = S_SQRT; step_nxt = '0;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1; step_nxt = step_r + 5'd1;
        if (step_r == 5'd23) state_nxt = S_XI;
      end
      S_XI: begin
        cmd.x_init = 1'b1; state_nxt = S_ROT; step_nxt = '0;
      end
      S_ROT: begin
        cmd.rot_step = 1'b1; step_nxt = step_r + 5'd1;
        if (step_r == 5'(gpna_pkg::CORDIC_STEPS - 1)) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1; state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1 = 1'b1; state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1; state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || out_fire) begin
          cmd.out_load = 1'b1; ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= '0;
      phase_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      phase_r <= phase_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign step = (state_r == S_SQRT) ? step_r : step_r;

endmodule

### src/gaussian_pixel_noise_adder.sv
// Adds Box-Muller gaussian noise to pixel channel bytes, one request at a time.
// The first request of a pair runs 16 log2 squaring steps, one multiply, 24 square
// root steps and 18 cordic rotations on one shared datapath, then two scaling
// multiplies; the second request reuses the held sample and goes straight to the
// two scaling multiplies. A new request is taken while the last result waits.
module gaussian_pixel_noise_adder #(
  parameter int UNIFORM_BITS = gpna_pkg::UNIFORM_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // channel_value[7:0], uniform_a, uniform_b, zero fill
  input  logic [((8 + 2*UNIFORM_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // noisy_value[7:0]
  output logic [7:0]  out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic signed [15:0] mean_r;
  logic [15:0] dev_r;
  logic [7:0] gain_r;
  logic busy, in_fire, out_fire;
  logic [4:0] step;
  gpna_pkg::gpna_cmd_t cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= gpna_pkg::MEAN_RST;
      dev_r <= gpna_pkg::DEV_RST;
      gain_r <= gpna_pkg::GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gpna_pkg::REG_MEAN: mean_r <= cfg_data;
        gpna_pkg::REG_DEV: dev_r <= cfg_data;
        gpna_pkg::REG_GAIN: gain_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  gpna_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
    .busy(busy), .out_valid(out_tvalid), .step(step), .cmd(cmd)
  );

  gpna_datapath #(.UNIFORM_BITS(UNIFORM_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .step(step),
    .channel_value(in_tdata[7:0]),
    .uniform_a(in_tdata[8 +: UNIFORM_BITS]),
    .uniform_b(in_tdata[8+UNIFORM_BITS +: UNIFORM_BITS]),
    .noise_mean(mean_r), .noise_deviation(dev_r), .noise_gain(gain_r),
    .noisy_value(out_tdata)
  );

endmodule

### src/gpna_checker.sv
// port-level checker bound to the top level
module gpna_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [7:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed under stall");
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared in the cycle after a request");

endmodule

bind gaussian_pixel_noise_adder gpna_checker u_gpna_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

### bench/testbench.sv
// self-checking stream testbench for the gaussian pixel noise adder
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = ((8 + 2*gpna_pkg::UNIFORM_BITS_DEF + 7) / 8) * 8;
  localparam int QUIET_LIMIT = 5000;
  localparam logic [1:0] REG_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = gpna_pkg::REG_MEAN;
  logic [15:0] cfg_data = '0;

  gaussian_pixel_noise_adder uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [DW-1:0] pixel_requests[$];
  logic [7:0] noisy_expected[$];
  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int quiet = 0;
  int hold_cnt = 0;
  bit hold_done = 0;
  bit calm = 0;

  // predictor state
  logic signed [15:0] mean_q8;
  logic [15:0] dev_q8;
  logic [7:0] gain_int;
  bit pair_second;
  logic signed [15:0] held_z;

  initial forever #10 clk = ~clk;

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic longint radius_of(input logic [15:0] code);
    longint unsigned x, m, frac, lg, t;
    int p;
    x = longint'(code) + 1;
    p = 0;
    while ((x >> (p + 1)) != 0) p++;
    m = x << (30 - p);
    frac = 0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    lg = (longint'(p) << 16) | frac;
    t = (64'd16 << 16) > lg ? (64'd16 << 16) - lg : 0;
    return longint'(int_sqrt((t * 64'd23258255) >> 16));
  endfunction

  function automatic logic signed [15:0] round_q12(input longint v);
    longint q;
    q = (v + 2048) >>> 12;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic logic [7:0] noisy_pixel(input logic [DW-1:0] d);
    longint r, x, y, c, s, ang, dx, dy, total, res;
    logic [31:0] ph;
    logic signed [15:0] z;
    if (!pair_second) begin
      r = radius_of(d[23:8]);
      ph = {d[39:24], 16'h0};
      ang = longint'(ph[29:0]);
      x = (r * 39797) >>> 4;
      y = 0;
      for (int i = 0; i < gpna_pkg::CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (ang >= 0) begin
          x -= dx; y += dy;
          ang -= longint'(gpna_pkg::atan_turn(i[gpna_pkg::STEP_W-1:0]));
        end else begin
          x += dx; y -= dy;
          ang += longint'(gpna_pkg::atan_turn(i[gpna_pkg::STEP_W-1:0]));
        end
      end
      case (ph[31:30])
        2'd0: begin c = x; s = y; end
        2'd1: begin c = -y; s = x; end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
      z = round_q12(c);
      held_z = round_q12(s);
      pair_second = 1;
    end else begin
      z = held_z;
      pair_second = 0;
    end
    total = longint'(d[7:0]) * 1048576
          + (longint'(z) * longint'(dev_q8) + longint'(mean_q8) * 4096) * longint'(gain_int);
    res = (total + 524288) >>> 20;
    if (res < 0) res = 0;
    if (res > 255) res = 255;
    return res[7:0];
  endfunction

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pixel_requests.size() > 0 && (calm || $urandom_range(99) >= 9)) begin
        in_tdata <= pixel_requests.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off while requests keep coming
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && n_in == 300) begin
      hold_done <= 1;
      hold_cnt <= 400;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && (calm || $urandom_range(99) >= 9);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        noisy_expected.push_back(noisy_pixel(in_tdata));
        n_in++;
      end
      if (out_tvalid && out_tready) begin
        n_out++;
        if (noisy_expected.size() == 0) report("unexpected noisy_value", out_tdata, -1);
        else begin
          if (out_tdata !== noisy_expected[0])
            report("noisy_value", out_tdata, noisy_expected[0]);
          void'(noisy_expected.pop_front());
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("gaussian_pixel_noise_adder verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == gpna_pkg::REG_MEAN) mean_q8 = val;
    else if (idx == gpna_pkg::REG_DEV) dev_q8 = val;
    else if (idx == gpna_pkg::REG_GAIN) gain_int = val[7:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_request(input logic [7:0] ch, input logic [15:0] a, input logic [15:0] b);
    pixel_requests.push_back({b, a, ch});
  endtask

  task automatic add_random(input int n);
    logic [15:0] a, b;
    logic [7:0] ch;
    for (int i = 0; i < n; i++) begin
      ch = 8'($urandom_range(255));
      a = 16'($urandom_range(65535));
      b = 16'($urandom_range(65535));
      if ($urandom_range(15) == 0) ch = $urandom_range(1) ? 8'hFF : 8'h00;
      if ($urandom_range(15) == 0) a = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      add_request(ch, a, b);
    end
  endtask

  task automatic drain;
    @(negedge clk);
    while (pixel_requests.size() != 0 || in_tvalid || noisy_expected.size() != 0)
      @(negedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    mean_q8 = gpna_pkg::MEAN_RST;
    dev_q8 = gpna_pkg::DEV_RST;
    gain_int = gpna_pkg::GAIN_RST;
    pair_second = 0;
    held_z = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, radius and quadrant extremes
    add_request(8'd0, 16'hFFFF, 16'h0000);
    add_request(8'd255, 16'h1234, 16'h5678);
    add_request(8'd128, 16'h0000, 16'h0000);
    add_request(8'd128, 16'hFFFF, 16'hFFFF);
    add_request(8'd100, 16'h0000, 16'h4000);
    add_request(8'd100, 16'h0000, 16'h0000);
    add_request(8'd100, 16'h0000, 16'h8000);
    add_request(8'd100, 16'hAAAA, 16'h5555);
    add_request(8'd100, 16'h0000, 16'hC000);
    add_request(8'd0, 16'h0000, 16'h0000);
    add_request(8'd50, 16'h0000, 16'hFFFF);
    add_request(8'd255, 16'h0001, 16'h2000);
    add_random(130);
    drain();

    // large swing, saturating both ways
    write_reg(gpna_pkg::REG_MEAN, 16'h8000);
    write_reg(gpna_pkg::REG_DEV, 16'hFFFF);
    write_reg(gpna_pkg::REG_GAIN, 16'h00FF);
    add_request(8'd255, 16'hFFFF, 16'h0000);
    add_request(8'd255, 16'h0000, 16'h0000);
    add_random(150);
    drain();

    // zero gain passes the channel through; unused index is ignored
    write_reg(gpna_pkg::REG_GAIN, 16'hAB00);
    write_reg(REG_NONE, 16'hFFFF);
    calm = 1;
    add_random(150);
    drain();
    calm = 0;

    write_reg(gpna_pkg::REG_MEAN, 16'h7FFF);
    write_reg(gpna_pkg::REG_DEV, 16'h0000);
    write_reg(gpna_pkg::REG_GAIN, 16'h0001);
    add_random(120);
    drain();

    write_reg(gpna_pkg::REG_MEAN, 16'h0000);
    write_reg(gpna_pkg::REG_DEV, 16'd2560);
    write_reg(gpna_pkg::REG_GAIN, 16'd3);
    add_random(150);
    drain();

    write_reg(gpna_pkg::REG_MEAN, 16'($urandom_range(65535)));
    write_reg(gpna_pkg::REG_DEV, 16'($urandom_range(4000)));
    write_reg(gpna_pkg::REG_GAIN, 16'($urandom_range(255)));
    add_random(100);
    drain();

    write_reg(gpna_pkg::REG_MEAN, gpna_pkg::MEAN_RST);
    write_reg(gpna_pkg::REG_DEV, gpna_pkg::DEV_RST);
    write_reg(gpna_pkg::REG_GAIN, 16'(gpna_pkg::GAIN_RST));
    add_random(130);
    drain();

    $display("%0d pixel requests and %0d results under seven register settings,", n_in, n_out);
    $display("with random stalls, a calm stretch and one long output hold-off");
    if (errors == 0 && noisy_expected.size() == 0)
      $display("gaussian_pixel_noise_adder verification clean");
    else
      $display("gaussian_pixel_noise_adder verification failed");
    $finish;
  end
endmodule
